### hw/rtl/thb_pkg.sv
`timescale 1ns / 1ps
// Package for the hysteresis threshold bank: table depth, derived widths,
// state and status codes, and the command and result records. No dependencies.

package thb_pkg;

  localparam int MaxThresholds = 8;
  localparam int IdxW = (MaxThresholds > 1) ? $clog2(MaxThresholds) : 1;
  localparam int CntW = $clog2(MaxThresholds + 1);

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_RANGE = 2'd1,
    STATUS_DUPLICATE = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TS_NORMAL = 2'd0,
    TS_HIGH   = 2'd1,
    TS_LOW    = 2'd2
  } trip_state_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_EVENT  = 1'b1
  } kind_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_ADD    = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_FINISH
  } back_state_e;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic               is_add;
    logic               bad_range;
    logic signed [31:0] value;
    logic [15:0]        id;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               inv;
  } cmd_t;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [15:0] id;
    trip_state_e state;
    logic        tripped;
    logic        last;
  } res_t;

endpackage

### hw/rtl/thb_front.sv
`timescale 1ns / 1ps
// Front of the threshold bank: accepts input items, classifies them and
// holds them in a two-entry command queue. Depends on thb_pkg.

module thb_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic                  action_i,
  input  logic signed [31:0]    sample_value_i,
  input  logic [15:0]           entry_id_i,
  input  logic signed [31:0]    low_limit_i,
  input  logic signed [31:0]    high_limit_i,
  input  logic                  invert_i,
  output logic                  cmd_valid_o,
  output thb_pkg::cmd_t         cmd_o,
  input  logic                  cmd_pop_i
);

  thb_pkg::cmd_t mem_q [2];
  logic [1:0]    cnt_q, cnt_d;
  logic          wr_q, rd_q;
  logic          wr_en, rd_en;
  thb_pkg::cmd_t cmd_in;

  always_comb begin
    cmd_in.is_add    = (action_i == thb_pkg::ACT_ADD);
    cmd_in.bad_range = (low_limit_i > high_limit_i);
    cmd_in.value     = sample_value_i;
    cmd_in.id        = entry_id_i;
    cmd_in.lo        = low_limit_i;
    cmd_in.hi        = high_limit_i;
    cmd_in.inv       = invert_i;
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_q];
  assign wr_en       = push && !full;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= cmd_in;
  end

endmodule

### hw/rtl/thb_back.sv
`timescale 1ns / 1ps
// Back of the threshold bank: holds the table and walks it one entry per
// unstalled cycle for samples and duplicate checks. Depends on thb_pkg.

module thb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  thb_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          res_full_i,
  output logic          res_push_o,
  output thb_pkg::res_t res_o
);

  localparam int MaxT = thb_pkg::MaxThresholds;
  localparam int IdxW = thb_pkg::IdxW;
  localparam int CntW = thb_pkg::CntW;

  thb_pkg::back_state_e state_q, state_d;
  logic [CntW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      count_q, count_d;
  thb_pkg::cmd_t        cmd_q, cmd_d;
  thb_pkg::status_e     status_q, status_d;
  thb_pkg::res_t        pend_q, pend_d;
  logic                 pend_vld_q, pend_vld_d;

  logic [15:0]              ids_q    [MaxT];
  logic signed [31:0]       lows_q   [MaxT];
  logic signed [31:0]       highs_q  [MaxT];
  logic                     invs_q   [MaxT];
  thb_pkg::trip_state_e     states_q [MaxT];

  logic [IdxW-1:0]      ix;
  logic [IdxW-1:0]      wx;
  logic                 at_end, match;
  thb_pkg::trip_state_e ns;
  thb_pkg::status_e     fin_status;
  logic                 st_we, add_we;

  assign ix = idx_q[IdxW-1:0];
  assign wx = count_q[IdxW-1:0];
  assign at_end = (idx_q == count_q);
  assign match = (ids_q[ix] == cmd_q.id) && (lows_q[ix] == cmd_q.lo) &&
                 (highs_q[ix] == cmd_q.hi) && (invs_q[ix] == cmd_q.inv);
  assign fin_status = (status_q == thb_pkg::STATUS_OK && count_q == CntW'(MaxT)) ?
                      thb_pkg::STATUS_FULL : status_q;

  // Hysteresis rule for the entry under the walk pointer
  always_comb begin
    ns = states_q[ix];
    if (!invs_q[ix]) begin
      if (cmd_q.value <= lows_q[ix])       ns = thb_pkg::TS_NORMAL;
      else if (cmd_q.value >= highs_q[ix]) ns = thb_pkg::TS_HIGH;
    end else begin
      if (cmd_q.value >= highs_q[ix])      ns = thb_pkg::TS_NORMAL;
      else if (cmd_q.value <= lows_q[ix])  ns = thb_pkg::TS_LOW;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    status_d    = status_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    cmd_pop_o   = 1'b0;
    res_push_o  = 1'b0;
    res_o       = pend_q;
    res_o.last  = 1'b0;
    st_we       = 1'b0;
    add_we      = 1'b0;
    case (state_q)
      thb_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          idx_d      = '0;
          pend_vld_d = 1'b0;
          status_d   = cmd_i.bad_range ? thb_pkg::STATUS_BAD_RANGE : thb_pkg::STATUS_OK;
          state_d    = thb_pkg::BK_WALK;
        end
      end
      thb_pkg::BK_WALK: begin
        if (cmd_q.is_add) begin
          if (status_q != thb_pkg::STATUS_OK || at_end) begin
            state_d = thb_pkg::BK_FINISH;
          end else if (match) begin
            status_d = thb_pkg::STATUS_DUPLICATE;
            state_d  = thb_pkg::BK_FINISH;
          end else begin
            idx_d = idx_q + CntW'(1);
          end
        end else if (at_end) begin
          state_d = thb_pkg::BK_FINISH;
        end else if (ns != states_q[ix]) begin
          // hold the walk while the previous event cannot be released
          if (!(pend_vld_q && res_full_i)) begin
            st_we          = 1'b1;
            res_push_o     = pend_vld_q;
            pend_d.kind    = thb_pkg::KIND_EVENT;
            pend_d.status  = thb_pkg::STATUS_OK;
            pend_d.id      = ids_q[ix];
            pend_d.state   = ns;
            pend_d.tripped = (ns != thb_pkg::TS_NORMAL);
            pend_d.last    = 1'b0;
            pend_vld_d     = 1'b1;
            idx_d          = idx_q + CntW'(1);
          end
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      thb_pkg::BK_FINISH: begin
        if (cmd_q.is_add) begin
          res_o.kind    = thb_pkg::KIND_STATUS;
          res_o.status  = fin_status;
          res_o.id      = '0;
          res_o.state   = thb_pkg::TS_NORMAL;
          res_o.tripped = 1'b0;
          res_o.last    = 1'b1;
          if (!res_full_i) begin
            res_push_o = 1'b1;
            if (fin_status == thb_pkg::STATUS_OK) begin
              add_we  = 1'b1;
              count_d = count_q + CntW'(1);
            end
            state_d = thb_pkg::BK_IDLE;
          end
        end else if (pend_vld_q) begin
          res_o.last = 1'b1;
          if (!res_full_i) begin
            res_push_o = 1'b1;
            pend_vld_d = 1'b0;
            state_d    = thb_pkg::BK_IDLE;
          end
        end else begin
          state_d = thb_pkg::BK_IDLE;
        end
      end
      default: state_d = thb_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= thb_pkg::BK_IDLE;
      count_q    <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cmd_q    <= cmd_d;
    status_q <= status_d;
    pend_q   <= pend_d;
    if (st_we) states_q[ix] <= ns;
    if (add_we) begin
      ids_q[wx]    <= cmd_q.id;
      lows_q[wx]   <= cmd_q.lo;
      highs_q[wx]  <= cmd_q.hi;
      invs_q[wx]   <= cmd_q.inv;
      states_q[wx] <= thb_pkg::TS_NORMAL;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxT))
    else $error("entry count beyond table depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full queue");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == thb_pkg::BK_WALK) |-> (idx_q <= count_q))
    else $error("walk pointer past the last entry");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> cmd_valid_i)
    else $error("command taken from an empty queue");

endmodule

### hw/rtl/thb_resq.sv
`timescale 1ns / 1ps
// Result queue of the threshold bank: two entries between the table walker
// and the consumer. Depends on thb_pkg.

module thb_resq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_push_i,
  input  thb_pkg::res_t res_i,
  output logic          res_full_o,
  output logic          empty,
  input  logic          pop,
  output thb_pkg::res_t res_o
);

  thb_pkg::res_t mem_q [2];
  logic [1:0]    cnt_q, cnt_d;
  logic          wr_q, rd_q;
  logic          wr_en, rd_en;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign res_o      = mem_q[rd_q];
  assign wr_en      = res_push_i && !res_full_o;
  assign rd_en      = pop && !empty;

  always_comb begin
    cnt_d = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_en) wr_q <= ~wr_q;
      if (rd_en) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_q] <= res_i;
  end

endmodule

### hw/rtl/hysteresis_threshold_bank_core.sv
`timescale 1ns / 1ps
// Top level of the hysteresis threshold bank: front command queue, table
// walker and result queue. Depends on thb_pkg, thb_front, thb_back, thb_resq.

// A bank of up to thb_pkg::MaxThresholds window comparators with hysteresis
// on one sensor. An add item appends an entry and returns one status
// transfer (ok, bad range, duplicate, table full); a sample item updates
// every entry and returns one event transfer per entry whose state changed,
// the final one marked last, or nothing at all if no entry changed. Both
// sides behave as queues: push while full is low, pop while empty is low.
// The back end walks the table one entry per cycle, but holds while a
// finished transfer waits for room in the result queue. A bad-range add
// or a duplicate found early ends its walk sooner. A two-entry command
// queue in front lets new items be taken during a walk, and a two-entry
// result queue behind lets finished transfers wait for pop.

module hysteresis_threshold_bank_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic signed [31:0] sample_value_i,
  input  logic [15:0]        entry_id_i,
  input  logic signed [31:0] low_limit_i,
  input  logic signed [31:0] high_limit_i,
  input  logic               invert_i,
  output logic               empty,
  input  logic               pop,
  output logic               kind_o,
  output logic [1:0]         status_o,
  output logic [15:0]        event_id_o,
  output logic [1:0]         new_state_o,
  output logic               tripped_o,
  output logic               last_o
);

  logic          cmd_valid, cmd_pop;
  thb_pkg::cmd_t cmd;
  logic          res_push, res_full;
  thb_pkg::res_t res_in, res_out;

  // Accept and classify incoming items
  thb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .sample_value_i(sample_value_i),
    .entry_id_i    (entry_id_i),
    .low_limit_i   (low_limit_i),
    .high_limit_i  (high_limit_i),
    .invert_i      (invert_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // Walk the table and produce status and event transfers
  thb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Hold finished transfers until the consumer pops them
  thb_resq u_resq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .res_push_i(res_push),
    .res_i     (res_in),
    .res_full_o(res_full),
    .empty     (empty),
    .pop       (pop),
    .res_o     (res_out)
  );

  assign kind_o      = res_out.kind;
  assign status_o    = res_out.status;
  assign event_id_o  = res_out.id;
  assign new_state_o = res_out.state;
  assign tripped_o   = res_out.tripped;
  assign last_o      = res_out.last;

endmodule

### test/tb_hysteresis_threshold_bank_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for hysteresis_threshold_bank_core: drives add and
// sample transfers, predicts status and change events, checks every result.
// Depends on thb_pkg and the hysteresis_threshold_bank_core RTL.

module tb_hysteresis_threshold_bank_core;

  localparam int RandomItems = 98;
  localparam int CalmItems   = 30;    // tail of the run with no idling at all
  localparam int DrainCycles = 40;    // covers a full walk plus both queues
  localparam int CycleLimit  = 200000;
  localparam logic signed [31:0] IntMin = 32'sh8000_0000;
  localparam logic signed [31:0] IntMax = 32'sh7fff_ffff;

  // One input transfer, every field at its port width
  typedef struct {
    thb_pkg::action_e   action;
    logic signed [31:0] value;
    logic [15:0]        id;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic               inv;
  } bank_item_t;

  // Shadow copy of the threshold table plus the queue of results still owed.
  // note_item advances the shadow table for every accepted input transfer;
  // check_result compares each popped result with the oldest one owed.
  class bank_scoreboard;
    logic [15:0]          ids    [thb_pkg::MaxThresholds];
    logic signed [31:0]   lows   [thb_pkg::MaxThresholds];
    logic signed [31:0]   highs  [thb_pkg::MaxThresholds];
    logic                 inverts[thb_pkg::MaxThresholds];
    thb_pkg::trip_state_e states [thb_pkg::MaxThresholds];
    int                   count;
    thb_pkg::res_t        owed_results[$];
    int                   errors;

    function void note_item(bank_item_t it);
      thb_pkg::res_t        r;
      thb_pkg::res_t        held;
      bit                   have_held;
      bit                   dup;
      thb_pkg::trip_state_e next;
      have_held = 1'b0;
      dup = 1'b0;
      r = '0;
      if (it.action == thb_pkg::ACT_ADD) begin
        r.kind = thb_pkg::KIND_STATUS;
        r.last = 1'b1;
        for (int i = 0; i < count; i++)
          if (ids[i] == it.id && lows[i] == it.lo && highs[i] == it.hi &&
              inverts[i] == it.inv)
            dup = 1'b1;
        // Bad range wins over duplicate, duplicate over a full table
        if (it.lo > it.hi) r.status = thb_pkg::STATUS_BAD_RANGE;
        else if (dup) r.status = thb_pkg::STATUS_DUPLICATE;
        else if (count >= thb_pkg::MaxThresholds) r.status = thb_pkg::STATUS_FULL;
        else begin
          r.status = thb_pkg::STATUS_OK;
          ids[count] = it.id;
          lows[count] = it.lo;
          highs[count] = it.hi;
          inverts[count] = it.inv;
          states[count] = thb_pkg::TS_NORMAL;
          count++;
        end
        owed_results.push_back(r);
        return;
      end
      // Walk the table in insertion order; hold each event back by one so
      // that the final one can be marked last
      for (int i = 0; i < count; i++) begin
        next = states[i];
        if (!inverts[i]) begin
          if (it.value <= lows[i]) next = thb_pkg::TS_NORMAL;
          else if (it.value >= highs[i]) next = thb_pkg::TS_HIGH;
        end else begin
          if (it.value >= highs[i]) next = thb_pkg::TS_NORMAL;
          else if (it.value <= lows[i]) next = thb_pkg::TS_LOW;
        end
        if (next != states[i]) begin
          states[i] = next;
          if (have_held) owed_results.push_back(held);
          held = '0;
          held.kind = thb_pkg::KIND_EVENT;
          held.status = thb_pkg::STATUS_OK;
          held.id = ids[i];
          held.state = next;
          held.tripped = (next != thb_pkg::TS_NORMAL);
          have_held = 1'b1;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        owed_results.push_back(held);
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic kind, logic [1:0] status, logic [15:0] id,
                               logic [1:0] state, logic tripped, logic last);
      thb_pkg::res_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: kind %0h, id %0h", kind, id);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      compare_field("kind", 16'(want.kind), 16'(kind));
      compare_field("status", 16'(want.status), 16'(status));
      compare_field("event_id", want.id, id);
      compare_field("new_state", 16'(want.state), 16'(state));
      compare_field("tripped", 16'(want.tripped), 16'(tripped));
      compare_field("last", 16'(want.last), 16'(last));
    endfunction
  endclass

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               push           = 1'b0;
  logic               full;
  logic               action_i       = thb_pkg::ACT_SAMPLE;
  logic signed [31:0] sample_value_i = '0;
  logic [15:0]        entry_id_i     = '0;
  logic signed [31:0] low_limit_i    = '0;
  logic signed [31:0] high_limit_i   = '0;
  logic               invert_i       = 1'b0;
  logic               empty;
  logic               pop            = 1'b0;
  logic               kind_o;
  logic [1:0]         status_o;
  logic [15:0]        event_id_o;
  logic [1:0]         new_state_o;
  logic               tripped_o;
  logic               last_o;

  bank_scoreboard sb;
  bit             gaps_on = 1'b1;
  int             cycles  = 0;

  hysteresis_threshold_bank_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .action_i       (action_i),
    .sample_value_i (sample_value_i),
    .entry_id_i     (entry_id_i),
    .low_limit_i    (low_limit_i),
    .high_limit_i   (high_limit_i),
    .invert_i       (invert_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .event_id_o     (event_id_o),
    .new_state_o    (new_state_o),
    .tripped_o      (tripped_o),
    .last_o         (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abandon a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic bank_item_t add_item(logic [15:0] id, logic signed [31:0] lo,
                                          logic signed [31:0] hi, logic inv);
    bank_item_t it;
    it.action = thb_pkg::ACT_ADD;
    it.value  = $urandom;    // unused by an add, toggle it anyway
    it.id     = id;
    it.lo     = lo;
    it.hi     = hi;
    it.inv    = inv;
    return it;
  endfunction

  function automatic bank_item_t sample_item(logic signed [31:0] value);
    bank_item_t it;
    it.action = thb_pkg::ACT_SAMPLE;
    it.value  = value;
    it.id     = 16'($urandom);    // unused by a sample
    it.lo     = $urandom;
    it.hi     = $urandom;
    it.inv    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // Offer one transfer and hold it until the block takes it. The optional idle
  // burst drops push first; otherwise push stays high from the previous item.
  // Handshake signals are read just after the edge, so they show the values
  // the edge itself saw.
  task automatic send_item(bank_item_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push           <= 1'b1;
    action_i       <= it.action;
    sample_value_i <= it.value;
    entry_id_i     <= it.id;
    low_limit_i    <= it.lo;
    high_limit_i   <= it.hi;
    invert_i       <= it.inv;
    do @(posedge clk_i); while (full);
    sb.note_item(it);
  endtask

  // Result side: check every transfer, stall pop in random bursts
  initial begin : result_drain
    int stall;
    stall = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty)
        sb.check_result(kind_o, status_o, event_id_o, new_state_o, tripped_o, last_o);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall = $urandom_range(0, 4);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int                 slot;
    int                 offset;
    int                 pick;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bank_item_t         it;
    sb = new;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. A sample on an empty table must yield nothing.
    send_item(sample_item(32'sd0));
    send_item(add_item(16'h0000, -32'sd100, 32'sd100, 1'b0));
    send_item(add_item(16'h0000, -32'sd100, 32'sd100, 1'b0));   // duplicate
    send_item(add_item(16'hffff, IntMax, IntMin, 1'b1));         // bad range
    send_item(add_item(16'hffff, -32'sd100, 32'sd100, 1'b1));
    send_item(add_item(16'h1234, IntMin, IntMax, 1'b0));         // widest window
    send_item(add_item(16'h8001, 32'sd0, 32'sd0, 1'b1));         // low equals high
    send_item(sample_item(32'sd100));                             // on the high limit
    send_item(sample_item(32'sd100));                             // no change at all
    send_item(sample_item(-32'sd100));                            // on the low limit
    send_item(sample_item(IntMax));
    send_item(sample_item(IntMin));
    send_item(sample_item(32'sd50));                              // only the 0..0 window changes
    // Fill the table
    send_item(add_item(16'h00ff, -32'sd10, 32'sd10, 1'b0));
    send_item(add_item(16'h7f00, -32'sd10, 32'sd10, 1'b1));
    send_item(add_item(16'h5a5a, -32'sd1000, 32'sd1000, 1'b0));
    send_item(add_item(16'ha5a5, -32'sd1, 32'sd1, 1'b1));
    // Rejections against a full table, in check order
    send_item(add_item(16'h2222, -32'sd5, 32'sd5, 1'b0));         // full
    send_item(add_item(16'h0000, -32'sd100, 32'sd100, 1'b0));     // duplicate first
    send_item(add_item(16'h3333, 32'sd7, 32'sd6, 1'b0));          // bad range first
    send_item(sample_item(32'sd20));
    send_item(sample_item(-32'sd20));

    // Random part: mostly samples aimed at the stored limits so that entries
    // keep crossing their windows, with some extremes, noise and bad adds
    for (int k = 0; k < RandomItems; k++) begin
      gaps_on = (k < RandomItems - CalmItems);
      slot = $urandom_range(0, sb.count - 1);
      pick = $urandom_range(0, 99);
      if (pick < 56) begin
        offset = int'($urandom_range(0, 4)) - 2;
        a = $urandom_range(0, 1) ? sb.lows[slot] : sb.highs[slot];
        it = sample_item(a + offset);
      end else if (pick < 64) begin
        it = sample_item($urandom_range(0, 1) ? IntMax : IntMin);
      end else if (pick < 80) begin
        it = sample_item($urandom);
      end else if (pick < 87) begin
        it = add_item(sb.ids[slot], sb.lows[slot], sb.highs[slot], sb.inverts[slot]);
      end else begin
        // Random window: roughly half of these have low above high
        a = $urandom;
        b = $urandom;
        it = add_item(16'($urandom), a, b, 1'($urandom_range(0, 1)));
      end
      send_item(it);
    end
    push <= 1'b0;

    // Drain: wait for every owed result, then watch for strays
    while (sb.owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
